// File: hdl/mant_pkg.sv
package mant_pkg;

  localparam int MAX_HELD_DEF = 32;
  localparam int CHANNELS_DEF = 16;
  localparam int PITCHES      = 128;
  localparam int PITCH_W      = 7;
  localparam int CHAN_W       = 5;
  localparam int VEL_W        = 32;
  localparam int STAMP_W      = 48;

  typedef enum logic [2:0] {
    FN_NOTE_ON     = 3'd0,
    FN_NOTE_OFF    = 3'd1,
    FN_SUSTAIN_ON  = 3'd2,
    FN_SUSTAIN_OFF = 3'd3,
    FN_RELEASE_ALL = 3'd4,
    FN_RESTART     = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    EV_NOTE_ON     = 2'd0,
    EV_NOTE_OFF    = 2'd1,
    EV_SUSTAIN_ON  = 2'd2,
    EV_SUSTAIN_OFF = 2'd3
  } ev_t;

  // control strobes from the sequencer to the note map
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } map_ctl_t;

  function automatic logic [STAMP_W-1:0] stamp_inc(input logic [STAMP_W-1:0] t);
    logic [STAMP_W-1:0] r;
    r = (t == {STAMP_W{1'b1}}) ? t : t + {{(STAMP_W-1){1'b0}}, 1'b1};
    return r;
  endfunction

endpackage

// File: hdl/mant_map_mem.sv
module mant_map_mem #(
  parameter int CHANNELS = mant_pkg::CHANNELS_DEF,
  parameter int AW       = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mant_pkg::map_ctl_t          ctl,
  input  logic [AW-1:0]               addr,
  input  logic [mant_pkg::PITCHES-1:0] wr_data,
  output logic [mant_pkg::PITCHES-1:0] rd_data
);

  logic [mant_pkg::PITCHES-1:0] mem [CHANNELS];
  logic [mant_pkg::PITCHES-1:0] q_r;
  logic [CHANNELS-1:0]          vld_r;
  logic                         q_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q_r <= mem[addr];
    end
  end

  // a row that was never written since the last clear reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        q_vld_r <= vld_r[addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

// File: hdl/midi_active_note_tracker.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    func, channel, pitch, velocity, stamp
// out_     output     out_valid / out_ready  event_type, channel, pitch, velocity,
//                                            stamp, synthetic, overflow_seen, last
//
// Note events pass accept and map row read, decide and write back, then emit; a
// retriggered note adds a synthetic note-off first, a refused or dropped note ends at
// decide. Sustain goes straight to emit; restart and unknown words stay idle. Release-all
// reads rows in channel order up to the last held note, stepping each pitch of a row
// holding notes, then a sustain-off if held and a clear. Reset is synchronous; per-row
// valid bits clear the map. A stalled output holds its word; in_ready returns in idle.
module midi_active_note_tracker #(
  parameter int MAX_HELD = mant_pkg::MAX_HELD_DEF,
  parameter int CHANNELS = mant_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [4:0]  in_channel,
  input  logic [6:0]  in_pitch,
  input  logic [31:0] in_velocity,
  input  logic [47:0] in_stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_type,
  output logic [4:0]  out_channel,
  output logic [6:0]  out_pitch,
  output logic [31:0] out_velocity,
  output logic [47:0] out_stamp,
  output logic        out_synthetic,
  output logic        out_overflow_seen,
  output logic        out_last
);

  localparam int CNT_W = $clog2(MAX_HELD + 1);
  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = mant_pkg::PITCH_W;
  localparam int CW    = mant_pkg::CHAN_W;
  localparam int SW    = mant_pkg::STAMP_W;
  localparam int VW    = mant_pkg::VEL_W;
  localparam int NP    = mant_pkg::PITCHES;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DEC    = 9'b000000010,
    ST_EMA    = 9'b000000100,
    ST_EMB    = 9'b000001000,
    ST_SC_RD  = 9'b000010000,
    ST_SC_WT  = 9'b000100000,
    ST_SC_BIT = 9'b001000000,
    ST_SC_SUS = 9'b010000000,
    ST_SC_END = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               sus_r, sus_nxt;
  logic [SW-1:0]      latest_r, latest_nxt;
  logic               ovf_r, ovf_nxt;

  logic [CW-1:0]      it_ch_r, it_ch_nxt;
  logic [PW-1:0]      it_pitch_r, it_pitch_nxt;
  logic [VW-1:0]      it_vel_r, it_vel_nxt;
  logic [SW-1:0]      stamp_r, stamp_nxt;
  logic               it_on_r, it_on_nxt;
  mant_pkg::ev_t      em_type_r, em_type_nxt;
  logic [AW-1:0]      scan_ch_r, scan_ch_nxt;
  logic [PW-1:0]      scan_p_r, scan_p_nxt;
  logic [NP-1:0]      row_r, row_nxt;

  logic               out_valid_r, out_valid_nxt;
  mant_pkg::ev_t      o_type_r, o_type_nxt;
  logic [CW-1:0]      o_ch_r, o_ch_nxt;
  logic [PW-1:0]      o_pitch_r, o_pitch_nxt;
  logic [VW-1:0]      o_vel_r, o_vel_nxt;
  logic [SW-1:0]      o_stamp_r, o_stamp_nxt;
  logic               o_syn_r, o_syn_nxt;
  logic               o_ovf_r, o_ovf_nxt;
  logic               o_last_r, o_last_nxt;

  mant_pkg::map_ctl_t map_ctl;
  logic [AW-1:0]      map_addr;
  logic [NP-1:0]      map_wdata;
  logic [NP-1:0]      map_rdata;

  logic               out_free;
  logic               in_acc;
  logic               ch_ok;
  logic [SW-1:0]      clamped;
  logic [CW-1:0]      ch_m1;
  logic [NP-1:0]      pmask;
  logic               held;
  logic               row_last;

  mant_map_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (map_ctl),
    .addr    (map_addr),
    .wr_data (map_wdata),
    .rd_data (map_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ch_ok    = (in_channel != '0) && (in_channel <= CW'(CHANNELS));
  assign clamped  = (in_stamp < latest_r) ? latest_r : in_stamp;
  assign ch_m1    = in_channel - CW'(1);
  assign pmask    = NP'(1) << it_pitch_r;
  assign held     = map_rdata[it_pitch_r];
  assign row_last = (scan_ch_r == AW'(CHANNELS - 1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sus_nxt       = sus_r;
    latest_nxt    = latest_r;
    ovf_nxt       = ovf_r;
    it_ch_nxt     = it_ch_r;
    it_pitch_nxt  = it_pitch_r;
    it_vel_nxt    = it_vel_r;
    stamp_nxt     = stamp_r;
    it_on_nxt     = it_on_r;
    em_type_nxt   = em_type_r;
    scan_ch_nxt   = scan_ch_r;
    scan_p_nxt    = scan_p_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_type_nxt    = o_type_r;
    o_ch_nxt      = o_ch_r;
    o_pitch_nxt   = o_pitch_r;
    o_vel_nxt     = o_vel_r;
    o_stamp_nxt   = o_stamp_r;
    o_syn_nxt     = o_syn_r;
    o_ovf_nxt     = o_ovf_r;
    o_last_nxt    = o_last_r;
    map_ctl       = '0;
    map_addr      = AW'(ch_m1);
    map_wdata     = map_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          it_ch_nxt    = in_channel;
          it_pitch_nxt = in_pitch;
          it_vel_nxt   = in_velocity;
          stamp_nxt    = clamped;
          case (in_func)
            mant_pkg::FN_NOTE_ON, mant_pkg::FN_NOTE_OFF: begin
              latest_nxt = clamped;
              it_on_nxt  = (in_func == mant_pkg::FN_NOTE_ON);
              if (ch_ok) begin
                map_ctl.rd_en = 1'b1;
                state_nxt     = ST_DEC;
              end
            end
            mant_pkg::FN_SUSTAIN_ON: begin
              latest_nxt   = clamped;
              sus_nxt      = 1'b1;
              it_pitch_nxt = '0;
              em_type_nxt  = mant_pkg::EV_SUSTAIN_ON;
              state_nxt    = ST_EMB;
            end
            mant_pkg::FN_SUSTAIN_OFF: begin
              latest_nxt   = clamped;
              sus_nxt      = 1'b0;
              it_pitch_nxt = '0;
              em_type_nxt  = mant_pkg::EV_SUSTAIN_OFF;
              state_nxt    = ST_EMB;
            end
            mant_pkg::FN_RELEASE_ALL: begin
              stamp_nxt   = mant_pkg::stamp_inc(latest_r);
              scan_ch_nxt = '0;
              if (count_r != '0) begin
                state_nxt = ST_SC_RD;
              end else if (sus_r) begin
                state_nxt = ST_SC_SUS;
              end
            end
            mant_pkg::FN_RESTART: begin
              latest_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_DEC: begin
        map_addr = AW'(it_ch_r - CW'(1));
        if (it_on_r) begin
          em_type_nxt = mant_pkg::EV_NOTE_ON;
          if (held) begin
            state_nxt = ST_EMA;
          end else if (count_r >= CNT_W'(MAX_HELD)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            map_ctl.wr_en = 1'b1;
            map_wdata     = map_rdata | pmask;
            count_nxt     = count_r + CNT_W'(1);
            state_nxt     = ST_EMB;
          end
        end else begin
          em_type_nxt = mant_pkg::EV_NOTE_OFF;
          if (held) begin
            map_ctl.wr_en = 1'b1;
            map_wdata     = map_rdata & ~pmask;
            count_nxt     = count_r - CNT_W'(1);
            state_nxt     = ST_EMB;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      // synthetic note-off ahead of a retriggered note
      ST_EMA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_type_nxt    = mant_pkg::EV_NOTE_OFF;
          o_ch_nxt      = it_ch_r;
          o_pitch_nxt   = it_pitch_r;
          o_vel_nxt     = '0;
          o_stamp_nxt   = stamp_r;
          o_syn_nxt     = 1'b1;
          o_ovf_nxt     = ovf_r;
          o_last_nxt    = 1'b0;
          state_nxt     = ST_EMB;
        end
      end

      ST_EMB: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_type_nxt    = em_type_r;
          o_ch_nxt      = it_ch_r;
          o_pitch_nxt   = it_pitch_r;
          o_vel_nxt     = it_vel_r;
          o_stamp_nxt   = stamp_r;
          o_syn_nxt     = 1'b0;
          o_ovf_nxt     = ovf_r;
          o_last_nxt    = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_SC_RD: begin
        map_addr      = scan_ch_r;
        map_ctl.rd_en = 1'b1;
        state_nxt     = ST_SC_WT;
      end

      ST_SC_WT: begin
        row_nxt    = map_rdata;
        scan_p_nxt = '0;
        if (map_rdata != '0) begin
          state_nxt = ST_SC_BIT;
        end else if (row_last) begin
          state_nxt = ST_SC_END;
        end else begin
          scan_ch_nxt = scan_ch_r + AW'(1);
          state_nxt   = ST_SC_RD;
        end
      end

      ST_SC_BIT: begin
        if (!row_r[scan_p_r] || out_free) begin
          if (row_r[scan_p_r]) begin
            out_valid_nxt = 1'b1;
            o_type_nxt    = mant_pkg::EV_NOTE_OFF;
            o_ch_nxt      = CW'(scan_ch_r) + CW'(1);
            o_pitch_nxt   = scan_p_r;
            o_vel_nxt     = '0;
            o_stamp_nxt   = stamp_r;
            o_syn_nxt     = 1'b1;
            o_ovf_nxt     = ovf_r;
            o_last_nxt    = (count_r == CNT_W'(1)) && !sus_r;
            latest_nxt    = stamp_r;
            stamp_nxt     = mant_pkg::stamp_inc(stamp_r);
            count_nxt     = count_r - CNT_W'(1);
          end
          // advance to the next pitch, next row or the tail of the scan
          if (count_nxt == '0) begin
            state_nxt = sus_r ? ST_SC_SUS : ST_SC_END;
          end else if (scan_p_r == PW'(NP - 1)) begin
            if (row_last) begin
              state_nxt = ST_SC_END;
            end else begin
              scan_ch_nxt = scan_ch_r + AW'(1);
              state_nxt   = ST_SC_RD;
            end
          end else begin
            scan_p_nxt = scan_p_r + PW'(1);
          end
        end
      end

      ST_SC_SUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_type_nxt    = mant_pkg::EV_SUSTAIN_OFF;
          o_ch_nxt      = CW'(1);
          o_pitch_nxt   = '0;
          o_vel_nxt     = '0;
          o_stamp_nxt   = stamp_r;
          o_syn_nxt     = 1'b1;
          o_ovf_nxt     = ovf_r;
          o_last_nxt    = 1'b1;
          latest_nxt    = stamp_r;
          sus_nxt       = 1'b0;
          state_nxt     = ST_SC_END;
        end
      end

      ST_SC_END: begin
        map_ctl.clr_all = 1'b1;
        count_nxt       = '0;
        sus_nxt         = 1'b0;
        state_nxt       = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sus_r       <= 1'b0;
      latest_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sus_r       <= sus_nxt;
      latest_r    <= latest_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_ch_r    <= it_ch_nxt;
    it_pitch_r <= it_pitch_nxt;
    it_vel_r   <= it_vel_nxt;
    stamp_r    <= stamp_nxt;
    it_on_r    <= it_on_nxt;
    em_type_r  <= em_type_nxt;
    scan_ch_r  <= scan_ch_nxt;
    scan_p_r   <= scan_p_nxt;
    row_r      <= row_nxt;
    o_type_r   <= o_type_nxt;
    o_ch_r     <= o_ch_nxt;
    o_pitch_r  <= o_pitch_nxt;
    o_vel_r    <= o_vel_nxt;
    o_stamp_r  <= o_stamp_nxt;
    o_syn_r    <= o_syn_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_event_type    = o_type_r;
  assign out_channel       = o_ch_r;
  assign out_pitch         = o_pitch_r;
  assign out_velocity      = o_vel_r;
  assign out_stamp         = o_stamp_r;
  assign out_synthetic     = o_syn_r;
  assign out_overflow_seen = o_ovf_r;
  assign out_last          = o_last_r;

endmodule

// File: hdl/mant_checker.sv
module mant_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_func,
  input logic [4:0]  in_channel,
  input logic [6:0]  in_pitch,
  input logic [31:0] in_velocity,
  input logic [47:0] in_stamp,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_event_type,
  input logic [4:0]  out_channel,
  input logic [6:0]  out_pitch,
  input logic [31:0] out_velocity,
  input logic [47:0] out_stamp,
  input logic        out_synthetic,
  input logic        out_overflow_seen,
  input logic        out_last
);

  logic seen_r;

  // remember an overflow reported on any delivered word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready && out_overflow_seen) begin
      seen_r <= 1'b1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stamp) && $stable(out_last)
      && $stable(out_event_type) && $stable(out_pitch))
    else $error("stalled output word changed");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> out_overflow_seen)
    else $error("overflow flag dropped");

  a_no_synthetic_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_synthetic |->
      out_event_type == mant_pkg::EV_NOTE_OFF || out_event_type == mant_pkg::EV_SUSTAIN_OFF)
    else $error("synthetic word is not a release");

  a_sustain_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_type == mant_pkg::EV_SUSTAIN_ON
      || out_event_type == mant_pkg::EV_SUSTAIN_OFF) |-> out_pitch == 7'd0)
    else $error("sustain word carries a pitch");

endmodule

bind midi_active_note_tracker mant_checker u_mant_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_HELD = mant_pkg::MAX_HELD_DEF;
  localparam int CHANNELS = mant_pkg::CHANNELS_DEF;
  localparam logic [2:0] FN_RSVD_6 = 3'd6;
  localparam logic [2:0] FN_RSVD_7 = 3'd7;
  localparam logic [mant_pkg::STAMP_W-1:0] STAMP_MAX = '1;
  localparam int N_RAND = 145;
  localparam int DRAIN_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    mant_pkg::ev_t                ev;
    logic [mant_pkg::CHAN_W-1:0]  ch;
    logic [mant_pkg::PITCH_W-1:0] p;
    logic [mant_pkg::VEL_W-1:0]   vel;
    logic [mant_pkg::STAMP_W-1:0] st;
    logic                         syn;
    logic                         ovf;
    logic                         last;
  } note_word_t;

  // n_typed: -1 take the tracker's words, otherwise the typed word count (0 or 1)
  typedef struct packed {
    logic [2:0]                   fn;
    logic [mant_pkg::CHAN_W-1:0]  ch;
    logic [mant_pkg::PITCH_W-1:0] p;
    logic [mant_pkg::VEL_W-1:0]   vel;
    logic [mant_pkg::STAMP_W-1:0] st;
    int                           n_typed;
    note_word_t                   word;
  } stim_t;

  localparam note_word_t NO_WORD = '0;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_func;
  logic [4:0]         in_channel;
  logic [6:0]         in_pitch;
  logic [31:0]        in_velocity;
  logic [47:0]        in_stamp;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_event_type;
  logic [4:0]         out_channel;
  logic [6:0]         out_pitch;
  logic [31:0]        out_velocity;
  logic [47:0]        out_stamp;
  logic               out_synthetic;
  logic               out_overflow_seen;
  logic               out_last;

  // note tracker copy
  bit [mant_pkg::PITCHES-1:0]   note_rows [0:CHANNELS-1];
  int                           held_total;
  bit                           sustain_down;
  bit [mant_pkg::STAMP_W-1:0]   clock_floor;
  bit                           overflow_sticky;

  note_word_t                   new_words [$];
  note_word_t                   pending_words [$];
  logic [11:0]                  sounding [$];
  stim_t                        dir_tab [23];
  logic [mant_pkg::STAMP_W-1:0] clock_run;
  int                           burst_left;
  int                           sent_items;
  int                           mismatches;

  midi_active_note_tracker DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_channel       (in_channel),
    .in_pitch         (in_pitch),
    .in_velocity      (in_velocity),
    .in_stamp         (in_stamp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_type   (out_event_type),
    .out_channel      (out_channel),
    .out_pitch        (out_pitch),
    .out_velocity     (out_velocity),
    .out_stamp        (out_stamp),
    .out_synthetic    (out_synthetic),
    .out_overflow_seen(out_overflow_seen),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [mant_pkg::STAMP_W-1:0] sat_inc(
      input logic [mant_pkg::STAMP_W-1:0] t);
    return (t == STAMP_MAX) ? t : t + 48'd1;
  endfunction

  function automatic void add_word(input mant_pkg::ev_t ev, input logic [4:0] ch,
                                   input logic [6:0] p, input logic [31:0] vel,
                                   input logic [47:0] st, input logic syn);
    note_word_t w;
    w = '{ev, ch, p, vel, st, syn, 1'b0, 1'b0};
    new_words = {new_words, w};
  endfunction

  function automatic void track_event(input logic [2:0] fn, input logic [4:0] ch,
                                      input logic [6:0] p, input logic [31:0] vel,
                                      input logic [47:0] st);
    bit held;
    logic [47:0] t;
    logic [47:0] t_end;
    new_words.delete();
    if (fn <= mant_pkg::FN_SUSTAIN_OFF) begin
      if (st < clock_floor) st = clock_floor;
      clock_floor = st;
    end
    case (fn)
      mant_pkg::FN_NOTE_ON, mant_pkg::FN_NOTE_OFF: begin
        if (ch >= 1 && ch <= CHANNELS) begin
          held = note_rows[ch-1][p];
          if (fn == mant_pkg::FN_NOTE_ON) begin
            if (held) begin
              add_word(mant_pkg::EV_NOTE_OFF, ch, p, '0, st, 1'b1);
              add_word(mant_pkg::EV_NOTE_ON, ch, p, vel, st, 1'b0);
            end else if (held_total >= MAX_HELD) begin
              overflow_sticky = 1'b1;
            end else begin
              note_rows[ch-1][p] = 1'b1;
              held_total++;
              add_word(mant_pkg::EV_NOTE_ON, ch, p, vel, st, 1'b0);
            end
          end else if (held) begin
            note_rows[ch-1][p] = 1'b0;
            held_total--;
            add_word(mant_pkg::EV_NOTE_OFF, ch, p, vel, st, 1'b0);
          end
        end
      end
      mant_pkg::FN_SUSTAIN_ON, mant_pkg::FN_SUSTAIN_OFF: begin
        sustain_down = (fn == mant_pkg::FN_SUSTAIN_ON);
        add_word(mant_pkg::ev_t'(fn[1:0]), ch, '0, vel, st, 1'b0);
      end
      mant_pkg::FN_RELEASE_ALL: begin
        t = sat_inc(clock_floor);
        t_end = clock_floor;
        for (int c = 0; c < CHANNELS; c++) begin
          for (int q = 0; q < mant_pkg::PITCHES; q++) begin
            if (note_rows[c][q] && new_words.size() < MAX_HELD) begin
              add_word(mant_pkg::EV_NOTE_OFF, 5'(c + 1), 7'(q), '0, t, 1'b1);
              t_end = t;
              t = sat_inc(t);
            end
          end
        end
        if (sustain_down) begin
          add_word(mant_pkg::EV_SUSTAIN_OFF, 5'd1, '0, '0, t, 1'b1);
          t_end = t;
        end
        foreach (note_rows[c]) note_rows[c] = '0;
        held_total = 0;
        sustain_down = 1'b0;
        clock_floor = t_end;
      end
      mant_pkg::FN_RESTART: clock_floor = '0;
      default: ;
    endcase
    foreach (new_words[k]) begin
      new_words[k].ovf = overflow_sticky;
      new_words[k].last = (k == new_words.size() - 1);
    end
  endfunction

  function automatic stim_t make_word(input logic [2:0] fn, input logic [4:0] ch,
                                      input logic [6:0] p);
    stim_t s;
    int r;
    s = '0;
    s.fn = fn;
    s.ch = ch;
    s.p = p;
    s.vel = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 127)) : 32'($urandom);
    r = $urandom_range(0, 15);
    if (r == 0) begin
      s.st = {16'($urandom), 32'($urandom)};
    end else if (r <= 2) begin
      // step back in time to exercise clamping
      s.st = clock_run - 48'($urandom_range(0, 5000));
    end else begin
      clock_run = clock_run + 48'($urandom_range(1, 2000));
      s.st = clock_run;
    end
    s.n_typed = -1;
    s.word = NO_WORD;
    return s;
  endfunction

  function automatic stim_t release_word();
    sounding.delete();
    return make_word(mant_pkg::FN_RELEASE_ALL, 5'($urandom_range(0, 31)),
                     7'($urandom_range(0, 127)));
  endfunction

  function automatic stim_t phrase_word();
    int r;
    int idx;
    logic [11:0] nt;
    r = $urandom_range(0, 99);
    idx = 0;
    nt = '0;
    if (sounding.size() == 0 && r >= 45 && r < 80) r = 0;
    if (sounding.size() != 0) begin
      idx = $urandom_range(0, sounding.size() - 1);
      nt = sounding[idx];
    end
    if (r < 45) begin
      nt = {5'($urandom_range(1, CHANNELS)), 7'($urandom_range(0, 127))};
      sounding = {sounding, nt};
      return make_word(mant_pkg::FN_NOTE_ON, nt[11:7], nt[6:0]);
    end
    if (r < 55) return make_word(mant_pkg::FN_NOTE_ON, nt[11:7], nt[6:0]);
    if (r < 80) begin
      sounding.delete(idx);
      return make_word(mant_pkg::FN_NOTE_OFF, nt[11:7], nt[6:0]);
    end
    if (r < 86)
      return make_word($urandom_range(0, 1) ? mant_pkg::FN_SUSTAIN_ON
                                            : mant_pkg::FN_SUSTAIN_OFF,
                       5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    if (r < 90)
      return make_word(mant_pkg::FN_NOTE_OFF, 5'($urandom_range(1, CHANNELS)),
                       7'($urandom_range(0, 127)));
    if (r < 93)
      return make_word(mant_pkg::FN_RESTART, 5'($urandom_range(0, 31)), 7'($urandom));
    if (r < 96)
      return make_word($urandom_range(0, 1) ? mant_pkg::FN_NOTE_ON : mant_pkg::FN_NOTE_OFF,
                       $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(CHANNELS + 1, 31)),
                       7'($urandom_range(0, 127)));
    return make_word($urandom_range(0, 1) ? FN_RSVD_6 : FN_RSVD_7,
                     5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endfunction

  task automatic send_event(input stim_t s);
    int gap;
    in_valid    <= 1'b1;
    in_func     <= s.fn;
    in_channel  <= s.ch;
    in_pitch    <= s.p;
    in_velocity <= s.vel;
    in_stamp    <= s.st;
    do @(posedge clk); while (!in_ready);
    track_event(s.fn, s.ch, s.p, s.vel, s.st);
    if (s.n_typed < 0) begin
      foreach (new_words[k]) pending_words = {pending_words, new_words[k]};
    end else if (s.n_typed > 0) begin
      pending_words = {pending_words, s.word};
    end
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  function automatic void cmp_field(input string name, input logic [47:0] want,
                                    input logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_out
    note_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("out_event_type: expected none, actual %0h", out_event_type);
      end else begin
        w = pending_words[0];
        pending_words.delete(0);
        cmp_field("out_event_type", 48'(w.ev), 48'(out_event_type));
        cmp_field("out_channel", 48'(w.ch), 48'(out_channel));
        cmp_field("out_pitch", 48'(w.p), 48'(out_pitch));
        cmp_field("out_velocity", 48'(w.vel), 48'(out_velocity));
        cmp_field("out_stamp", w.st, out_stamp);
        cmp_field("out_synthetic", 48'(w.syn), 48'(out_synthetic));
        cmp_field("out_overflow_seen", 48'(w.ovf), 48'(out_overflow_seen));
        cmp_field("out_last", 48'(w.last), 48'(out_last));
      end
    end
  end

  initial begin : sink
    int mode;
    int len;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len = (mode == 3) ? $urandom_range(1, 30) : $urandom_range(10, 80);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin : watchdog
    int n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stim
    int ep;
    int kind;
    int len;
    stim_t s;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_func     <= '0;
    in_channel  <= '0;
    in_pitch    <= '0;
    in_velocity <= '0;
    in_stamp    <= '0;
    foreach (note_rows[c]) note_rows[c] = '0;
    held_total = 0;
    sustain_down = 1'b0;
    clock_floor = '0;
    overflow_sticky = 1'b0;
    clock_run = '0;
    burst_left = 0;
    sent_items = 0;
    mismatches = 0;

    dir_tab = '{
      '{mant_pkg::FN_SUSTAIN_ON, 5'd1, 7'h55, 32'hFFFF_FFFF, 48'd0, 1,
        '{mant_pkg::EV_SUSTAIN_ON, 5'd1, 7'd0, 32'hFFFF_FFFF, 48'd0, 1'b0, 1'b0, 1'b1}},
      '{mant_pkg::FN_NOTE_ON, 5'd1, 7'd0, 32'd0, 48'd100, 1,
        '{mant_pkg::EV_NOTE_ON, 5'd1, 7'd0, 32'd0, 48'd100, 1'b0, 1'b0, 1'b1}},
      // stamp behind the floor: clamp up
      '{mant_pkg::FN_NOTE_ON, 5'd16, 7'd127, 32'h8000_0001, 48'd50, 1,
        '{mant_pkg::EV_NOTE_ON, 5'd16, 7'd127, 32'h8000_0001, 48'd100,
          1'b0, 1'b0, 1'b1}},
      '{mant_pkg::FN_NOTE_ON, 5'd0, 7'd5, 32'd9, 48'd200, 0, NO_WORD},
      '{mant_pkg::FN_NOTE_ON, 5'd17, 7'd5, 32'd9, 48'd300, 0, NO_WORD},
      '{mant_pkg::FN_NOTE_OFF, 5'd31, 7'd127, 32'd9, 48'd0, 0, NO_WORD},
      '{mant_pkg::FN_NOTE_OFF, 5'd3, 7'd64, 32'd9, 48'd400, 0, NO_WORD},
      '{FN_RSVD_6, 5'd5, 7'd10, 32'd1, 48'd1000, 0, NO_WORD},
      '{FN_RSVD_7, 5'd1, 7'd0, 32'd1, 48'hFFFF_FFFF_FFFF, 0, NO_WORD},
      '{mant_pkg::FN_NOTE_ON, 5'd1, 7'd0, 32'h7F, 48'd500, -1, NO_WORD},
      '{mant_pkg::FN_NOTE_OFF, 5'd16, 7'd127, 32'h40, 48'd600, 1,
        '{mant_pkg::EV_NOTE_OFF, 5'd16, 7'd127, 32'h40, 48'd600, 1'b0, 1'b0, 1'b1}},
      '{mant_pkg::FN_NOTE_ON, 5'd8, 7'd64, 32'd1, 48'hFFFF_FFFF_FFFE, 1,
        '{mant_pkg::EV_NOTE_ON, 5'd8, 7'd64, 32'd1, 48'hFFFF_FFFF_FFFE,
          1'b0, 1'b0, 1'b1}},
      '{mant_pkg::FN_SUSTAIN_OFF, 5'd31, 7'd3, 32'd2, 48'd0, 1,
        '{mant_pkg::EV_SUSTAIN_OFF, 5'd31, 7'd0, 32'd2, 48'hFFFF_FFFF_FFFE,
          1'b0, 1'b0, 1'b1}},
      '{mant_pkg::FN_SUSTAIN_ON, 5'd16, 7'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 1,
        '{mant_pkg::EV_SUSTAIN_ON, 5'd16, 7'd0, 32'd0, 48'hFFFF_FFFF_FFFF,
          1'b0, 1'b0, 1'b1}},
      // release stamps pinned at the top
      '{mant_pkg::FN_RELEASE_ALL, 5'd9, 7'd9, 32'd9, 48'd9, -1, NO_WORD},
      '{mant_pkg::FN_RELEASE_ALL, 5'd0, 7'd0, 32'd0, 48'd0, 0, NO_WORD},
      '{mant_pkg::FN_RESTART, 5'd3, 7'd3, 32'd3, 48'd3, 0, NO_WORD},
      '{mant_pkg::FN_NOTE_ON, 5'd2, 7'd1, 32'd3, 48'd5, 1,
        '{mant_pkg::EV_NOTE_ON, 5'd2, 7'd1, 32'd3, 48'd5, 1'b0, 1'b0, 1'b1}},
      '{mant_pkg::FN_NOTE_ON, 5'd2, 7'd2, 32'd4, 48'd6, -1, NO_WORD},
      '{mant_pkg::FN_SUSTAIN_ON, 5'd2, 7'd0, 32'd5, 48'd7, -1, NO_WORD},
      '{mant_pkg::FN_RELEASE_ALL, 5'd1, 7'd1, 32'd1, 48'd1, -1, NO_WORD},
      '{mant_pkg::FN_NOTE_OFF, 5'd2, 7'd1, 32'd5, 48'd0, 0, NO_WORD},
      '{mant_pkg::FN_RESTART, 5'd0, 7'd0, 32'd0, 48'd0, 0, NO_WORD}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) send_event(dir_tab[k]);

    sent_items = 0;
    ep = 0;
    while (sent_items < N_RAND) begin
      kind = (ep == 4) ? 6 : $urandom_range(0, 9);
      if (kind <= 5) begin
        len = $urandom_range(6, 20);
        repeat (len) send_event(phrase_word());
        if ($urandom_range(0, 1)) send_event(release_word());
      end else if (kind <= 7) begin
        // push the map past its capacity
        len = $urandom_range(40, 48);
        repeat (len)
          send_event(make_word(mant_pkg::FN_NOTE_ON, 5'($urandom_range(1, CHANNELS)),
                               7'($urandom_range(0, 127))));
        if ($urandom_range(0, 1))
          send_event(make_word(mant_pkg::FN_SUSTAIN_ON, 5'($urandom_range(0, 31)), 7'd0));
        send_event(release_word());
      end else if (kind == 8) begin
        len = $urandom_range(3, 8);
        repeat (len)
          send_event(make_word(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                               7'($urandom_range(0, 127))));
      end else begin
        repeat (2) begin
          s = make_word(mant_pkg::FN_NOTE_ON, 5'($urandom_range(1, CHANNELS)),
                        7'($urandom_range(0, 127)));
          s.st = STAMP_MAX - 48'($urandom_range(0, 2));
          send_event(s);
        end
        send_event(release_word());
        send_event(make_word(mant_pkg::FN_RESTART, 5'd0, 7'd0));
      end
      ep++;
    end

    if (in_valid) in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
